// File: rtl/core/bll_pkg.sv
package bll_pkg;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_BUILD = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam int NODE_W  = 12;
    localparam int COUNT_W = 13;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_B_RD1,
        ST_B_RD2,
        ST_B_WR,
        ST_Q_DA,
        ST_Q_DB,
        ST_Q_LIFT_RD,
        ST_Q_LIFT,
        ST_Q_DESC_RD,
        ST_Q_DESC_B,
        ST_Q_DESC,
        ST_Q_PAR_RD,
        ST_Q_PAR,
        ST_OUT
    } state_t;

endpackage

// File: rtl/core/bll_mem.sv
module bll_mem
    import bll_pkg::*;
#(
    parameter int AW = 16,
    parameter int DW = 12
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/binary_lifting_lca.sv
// Binary-lifting lowest-common-ancestor engine. Load items (mode 0) write a node's parent and
// depth. A build item (mode 1) fills jump levels 1..LEVELS-1 for node_count nodes with two
// dependent reads and one write of the jump memory, which has one read and one write port:
// each entry reads the node's jump at the level below, then that ancestor's jump at the
// level below, then writes the result. A query (mode 2) reads both depths, lifts the deeper
// node over LEVELS levels, descends over LEVELS levels and then reads the parent; its result
// goes to the output register. A query whose nodes meet after lifting skips the descent, and
// a query with a node out of range goes straight to the output with bad_node set.
// One item is handled at a time; a result waits in an output register while the next item is
// accepted, and a query that finishes while that result is still held waits for it to leave.
module binary_lifting_lca
    import bll_pkg::*;
#(
    parameter int MAX_NODES = 4096,
    parameter int LEVELS    = 12
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          mode,
    input  logic [NODE_W-1:0]   node_index,
    input  logic [NODE_W-1:0]   parent_index,
    input  logic [NODE_W-1:0]   node_depth,
    input  logic [NODE_W-1:0]   first_node,
    input  logic [NODE_W-1:0]   second_node,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [NODE_W-1:0]   ancestor,
    output logic                bad_node,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [COUNT_W-1:0]  cfg_data
);

    localparam int NA  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int LW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int JAW = NA + LW;
    localparam int CW  = NA + 1;
    localparam logic [LW-1:0] TOP = LW'(LEVELS - 1);
    localparam logic [LW-1:0] LAST = LW'(LEVELS - 1);

    state_t state_reg, state_next;
    logic [COUNT_W-1:0] count_reg;
    logic [CW-1:0] lim;
    logic [NA-1:0] i_reg, i_next;
    logic [LW-1:0] lv_reg, lv_next;
    logic [NODE_W-1:0] a_reg, a_next, b_reg, b_next, t_reg, t_next;
    logic [NODE_W-1:0] da_reg, da_next, diff_reg, diff_next;
    logic [NODE_W-1:0] res_reg, res_next;
    logic bad_reg, bad_next, ov_reg, ov_next;
    logic [NODE_W-1:0] anc_reg, anc_next;
    logic flag_reg, flag_next;

    logic jwe, dwe;
    logic [JAW-1:0] jwa, jra;
    logic [NODE_W-1:0] jwd, jrd, drd;
    logic [NA-1:0] dra;

    logic accept;
    logic [NODE_W-1:0] diff_c;
    logic lift_bit;
    logic [NODE_W-1:0] lifted_b;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = ov_reg;
    assign ancestor  = anc_reg;
    assign bad_node  = flag_reg;
    assign lim = (count_reg > COUNT_W'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(count_reg);

    function automatic logic [JAW-1:0] ja(input logic [NODE_W-1:0] n, input logic [LW-1:0] l);
        ja = {NA'(n), l};
    endfunction

    bll_mem #(.AW(JAW), .DW(NODE_W)) u_jump (
        .clk(clk), .we(jwe), .waddr(jwa), .wdata(jwd), .raddr(jra), .rdata(jrd)
    );

    bll_mem #(.AW(NA), .DW(NODE_W)) u_depth (
        .clk(clk), .we(dwe), .waddr(NA'(node_index)), .wdata(node_depth),
        .raddr(dra), .rdata(drd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= COUNT_W'(1);
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg    <= i_next;
        lv_reg   <= lv_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        t_reg    <= t_next;
        da_reg   <= da_next;
        diff_reg <= diff_next;
        res_reg  <= res_next;
        bad_reg  <= bad_next;
        anc_reg  <= anc_next;
        flag_reg <= flag_next;
    end

    assign diff_c = (da_reg > drd) ? da_reg - drd : drd - da_reg;
    assign lift_bit = (32'(lv_reg) < NODE_W) ? diff_reg[lv_reg] : 1'b0;
    assign lifted_b = lift_bit ? jrd : b_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode)
                        MODE_BUILD:
                            state_next = (LEVELS > 1 && lim != '0) ? ST_B_RD1 : ST_IDLE;
                        MODE_QUERY:
                            state_next = (CW'(first_node) >= lim || CW'(second_node) >= lim)
                                ? ST_OUT : ST_Q_DA;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_B_RD1:     state_next = ST_B_RD2;
            ST_B_RD2:     state_next = ST_B_WR;
            ST_B_WR:
            begin
                if (CW'(i_reg) + CW'(1) < lim)
                    state_next = ST_B_RD1;
                else if (lv_reg != LAST)
                    state_next = ST_B_RD1;
                else
                    state_next = ST_IDLE;
            end
            ST_Q_DA:      state_next = ST_Q_DB;
            ST_Q_DB:      state_next = ST_Q_LIFT_RD;
            ST_Q_LIFT_RD: state_next = ST_Q_LIFT;
            ST_Q_LIFT:
            begin
                if (lv_reg != LAST)
                    state_next = ST_Q_LIFT_RD;
                else if (lifted_b == a_reg)
                    state_next = ST_OUT;
                else
                    state_next = ST_Q_DESC_RD;
            end
            ST_Q_DESC_RD: state_next = ST_Q_DESC_B;
            ST_Q_DESC_B:  state_next = ST_Q_DESC;
            ST_Q_DESC:    state_next = (lv_reg == '0) ? ST_Q_PAR_RD : ST_Q_DESC_RD;
            ST_Q_PAR_RD:  state_next = ST_Q_PAR;
            ST_Q_PAR:     state_next = ST_OUT;
            ST_OUT:       state_next = (ov_reg && out_stall) ? ST_OUT : ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        i_next    = i_reg;
        lv_next   = lv_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        t_next    = t_reg;
        da_next   = da_reg;
        diff_next = diff_reg;
        res_next  = res_reg;
        bad_next  = bad_reg;
        anc_next  = anc_reg;
        flag_next = flag_reg;
        ov_next   = ov_reg && out_stall;
        jwe = 1'b0;
        jwa = ja(node_index, '0);
        jwd = parent_index;
        jra = ja(a_reg, lv_reg);
        dwe = 1'b0;
        dra = NA'(first_node);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    i_next  = '0;
                    lv_next = (LEVELS > 1) ? LW'(1) : '0;
                    a_next  = first_node;
                    b_next  = second_node;
                    bad_next = 1'b1;
                    res_next = '0;
                    if (mode == MODE_LOAD && 32'(node_index) < MAX_NODES)
                    begin
                        jwe = 1'b1;
                        dwe = 1'b1;
                    end
                end
            end
            ST_B_RD1:
            begin
                jra = {i_reg, LW'(lv_reg - LW'(1))};
            end
            ST_B_RD2:
            begin
                jra = ja(jrd, LW'(lv_reg - LW'(1)));
            end
            ST_B_WR:
            begin
                jwe = 1'b1;
                jwa = {i_reg, lv_reg};
                jwd = jrd;
                if (CW'(i_reg) + CW'(1) < lim)
                    i_next = i_reg + NA'(1);
                else
                begin
                    i_next  = '0;
                    lv_next = lv_reg + LW'(1);
                end
            end
            ST_Q_DA:
            begin
                da_next = drd;
                dra = NA'(b_reg);
            end
            ST_Q_DB:
            begin
                da_next = drd;
                lv_next = '0;
                if (drd > da_reg)
                begin
                    diff_next = diff_c;
                end
                else
                begin
                    diff_next = diff_c;
                    a_next = b_reg;
                    b_next = a_reg;
                end
                if (da_reg > drd)
                begin
                    a_next = b_reg;
                    b_next = a_reg;
                end
                else
                begin
                    a_next = a_reg;
                    b_next = b_reg;
                end
            end
            ST_Q_LIFT_RD:
            begin
                jra = ja(b_reg, lv_reg);
            end
            ST_Q_LIFT:
            begin
                b_next = lifted_b;
                if (lv_reg != LAST)
                    lv_next = lv_reg + LW'(1);
                else
                begin
                    lv_next = TOP;
                    if (lifted_b == a_reg)
                    begin
                        res_next = a_reg;
                        bad_next = 1'b0;
                    end
                end
            end
            ST_Q_DESC_RD:
            begin
                jra = ja(a_reg, lv_reg);
            end
            ST_Q_DESC_B:
            begin
                t_next = jrd;
                jra = ja(b_reg, lv_reg);
            end
            ST_Q_DESC:
            begin
                if (t_reg != jrd)
                begin
                    a_next = t_reg;
                    b_next = jrd;
                end
                if (lv_reg != '0)
                    lv_next = lv_reg - LW'(1);
            end
            ST_Q_PAR_RD:
            begin
                jra = ja(a_reg, '0);
            end
            ST_Q_PAR:
            begin
                res_next = jrd;
                bad_next = 1'b0;
            end
            ST_OUT:
            begin
                if (!(ov_reg && out_stall))
                begin
                    ov_next   = 1'b1;
                    anc_next  = res_reg;
                    flag_next = bad_reg;
                end
            end
            default:
            begin
            end
        endcase
        if (state_reg == ST_IDLE && accept && mode == MODE_QUERY)
            dra = NA'(first_node);
    end

endmodule
